// ===== hdl/tcde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_pkg
// Shared sizes, word type and operation codes of the toy decode/execute core.
// ----------------------------------------------------------------------------
package tcde_pkg;

	localparam int REG_COUNT  = 16;
	localparam int DATA_WORDS = 256;
	localparam int DATA_WIDTH = 32;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);
	localparam int MEM_ADDR_W = $clog2(DATA_WORDS);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [REG_IDX_W-1:0]  reg_idx_t;
	typedef logic [MEM_ADDR_W-1:0] mem_addr_t;

	localparam logic [1:0] ACT_EXEC    = 2'd0;
	localparam logic [1:0] ACT_HOST_WR = 2'd1;
	localparam logic [1:0] ACT_HOST_RD = 2'd2;

	localparam logic [3:0] OP_ADD   = 4'd8;
	localparam logic [3:0] OP_SUB   = 4'd9;
	localparam logic [3:0] OP_LOAD  = 4'd12;
	localparam logic [3:0] OP_STORE = 4'd14;

	localparam logic [1:0] EFF_NONE    = 2'd0;
	localparam logic [1:0] EFF_REG_WR  = 2'd1;
	localparam logic [1:0] EFF_MEM_WR  = 2'd2;
	localparam logic [1:0] EFF_HOST_RD = 2'd3;

endpackage

// ===== hdl/toy_cpu_decode_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_decode_execute
// Single-issue execute stage of a tiny core with a register file and a data
// memory held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one action per transfer: execute an instruction
// word (add, sub, load, store), or a host write or host read of a data word.
// The output channel returns exactly one result per input transfer, in order:
// effect, register index, memory address and value.
// An input transfer loads the registered RAM reads and the execute slot; the
// execute cycle then writes back and loads the output register. Throughput is
// one transfer per cycle while the receiver keeps taking results; the execute
// cycle forwards the word written in the same cycle that a following item's
// RAM read was issued, so back-to-back dependent instructions need no bubble.
// Reset clears all control state; per-entry valid bits make every register
// and data word read as zero until it is first written, so no clearing pass
// is needed and the block accepts input right after reset.
// When the receiver stalls, the output register holds its result, the item
// in the execute cycle waits there, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module toy_cpu_decode_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [15:0]         instruction,
	input  logic [7:0]          host_address,
	input  tcde_pkg::word_t     host_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          effect,
	output logic [3:0]          register_index,
	output logic [7:0]          memory_address,
	output tcde_pkg::word_t     value
);

	import tcde_pkg::*;

	logic      accept;
	logic      adv;
	reg_idx_t  in_hi;
	reg_idx_t  in_mid;
	mem_addr_t in_maddr;

	logic      valid_s1;
	logic [1:0] action_s1;
	logic [3:0] op_s1;
	reg_idx_t  hi_s1;
	reg_idx_t  lo_s1;
	mem_addr_t addr_s1;
	word_t     hdata_s1;
	logic      rfa_ok_s1;
	logic      rfb_ok_s1;
	logic      dm_ok_s1;
	logic      fa_s1;
	logic      fb_s1;
	logic      fd_s1;
	word_t     frf_s1;
	word_t     fdm_s1;

	word_t     rda;
	word_t     rdb;
	word_t     rdm;
	word_t     opa;
	word_t     opb;
	word_t     opm;

	logic      rf_we;
	reg_idx_t  rf_waddr;
	logic      dm_we;
	mem_addr_t dm_waddr;
	word_t     res_val;
	logic [1:0] res_eff;
	reg_idx_t  res_reg;
	mem_addr_t res_addr;

	logic [REG_COUNT-1:0]  rf_valid_q;
	logic [DATA_WORDS-1:0] dm_valid_q;

	logic      out_valid_q;
	logic [1:0] effect_q;
	logic [3:0] reg_q;
	logic [7:0] addr_q;
	word_t     value_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	assign in_hi    = instruction[12 +: REG_IDX_W];
	assign in_mid   = instruction[8 +: REG_IDX_W];
	assign in_maddr = (action == ACT_EXEC) ? instruction[4 +: MEM_ADDR_W]
	                                       : host_address[MEM_ADDR_W-1:0];

	tcde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (res_val),
		.re    (accept),
		.raddr (in_hi),
		.rdata (rda)
	);

	tcde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (res_val),
		.re    (accept),
		.raddr (in_mid),
		.rdata (rdb)
	);

	tcde_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DATA_WORDS)) u_dm (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (res_val),
		.re    (accept),
		.raddr (in_maddr),
		.rdata (rdm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fa_s1    <= 1'b0;
			fb_s1    <= 1'b0;
			fd_s1    <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fa_s1    <= rf_we && (rf_waddr == in_hi);
			fb_s1    <= rf_we && (rf_waddr == in_mid);
			fd_s1    <= dm_we && (dm_waddr == in_maddr);
		end else if (adv) begin
			valid_s1 <= 1'b0;
			fa_s1    <= 1'b0;
			fb_s1    <= 1'b0;
			fd_s1    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			op_s1     <= instruction[3:0];
			hi_s1     <= in_hi;
			lo_s1     <= instruction[4 +: REG_IDX_W];
			addr_s1   <= in_maddr;
			hdata_s1  <= host_data;
			rfa_ok_s1 <= rf_valid_q[in_hi];
			rfb_ok_s1 <= rf_valid_q[in_mid];
			dm_ok_s1  <= dm_valid_q[in_maddr];
			frf_s1    <= res_val;
			fdm_s1    <= res_val;
		end
	end

	always_comb begin
		opa = fa_s1 ? frf_s1 : (rfa_ok_s1 ? rda : '0);
		opb = fb_s1 ? frf_s1 : (rfb_ok_s1 ? rdb : '0);
		opm = fd_s1 ? fdm_s1 : (dm_ok_s1 ? rdm : '0);
	end

	always_comb begin
		res_eff  = EFF_NONE;
		res_reg  = '0;
		res_addr = '0;
		res_val  = '0;
		rf_waddr = lo_s1;
		dm_waddr = addr_s1;
		case (action_s1)
			ACT_EXEC: begin
				case (op_s1)
					OP_ADD: begin
						res_eff = EFF_REG_WR;
						res_reg = lo_s1;
						res_val = opa + opb;
					end
					OP_SUB: begin
						res_eff = EFF_REG_WR;
						res_reg = lo_s1;
						res_val = opa - opb;
					end
					OP_LOAD: begin
						res_eff  = EFF_REG_WR;
						res_reg  = hi_s1;
						res_addr = addr_s1;
						res_val  = opm;
						rf_waddr = hi_s1;
					end
					OP_STORE: begin
						res_eff  = EFF_MEM_WR;
						res_addr = addr_s1;
						res_val  = opa;
					end
					default: begin
						res_eff = EFF_NONE;
					end
				endcase
			end
			ACT_HOST_WR: begin
				res_eff  = EFF_MEM_WR;
				res_addr = addr_s1;
				res_val  = hdata_s1;
			end
			ACT_HOST_RD: begin
				res_eff  = EFF_HOST_RD;
				res_addr = addr_s1;
				res_val  = opm;
			end
			default: begin
				res_eff = EFF_NONE;
			end
		endcase
		rf_we = adv && (res_eff == EFF_REG_WR);
		dm_we = adv && (res_eff == EFF_MEM_WR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			dm_valid_q <= '0;
		end else begin
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			if (dm_we) begin
				dm_valid_q[dm_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			effect_q <= res_eff;
			reg_q    <= 4'(res_reg);
			addr_q   <= 8'(res_addr);
			value_q  <= res_val;
		end
	end

	assign out_valid      = out_valid_q;
	assign effect         = effect_q;
	assign register_index = reg_q;
	assign memory_address = addr_q;
	assign value          = value_q;

`ifndef ASSERT_OFF
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_we && dm_we))
		else $error("Register file and data memory written in the same cycle.");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		(fa_s1 || fb_s1 || fd_s1) |-> valid_s1)
		else $error("Forwarding flag set without an item in the execute cycle.");

	a_rf_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |=> rf_valid_q[$past(rf_waddr)])
		else $error("Written register not marked valid.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> (!rf_we && !dm_we && !in_ready))
		else $error("State written or input taken while the output is stalled.");
`endif

endmodule

// ===== hdl/tcde_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/toy_cpu_decode_execute_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_decode_execute_test
// Self-checking bench for the toy decode/execute core. A queue of actions
// (host writes and reads, add, sub, load, store, unused opcodes and the
// unused action code) feeds a bursty sender. A shadow register file and data
// memory predict every result, and a monitor compares each output transfer
// with the oldest prediction while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module toy_cpu_decode_execute_test;

	import tcde_pkg::*;

	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam logic [3:0] OP_UNUSED_LOW  = 4'd0;
	localparam logic [3:0] OP_UNUSED_MID  = 4'd10;
	localparam logic [3:0] OP_UNUSED_HIGH = 4'd15;

	localparam int RANDOM_ACTIONS = 1650;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 150;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] instruction;
		logic [7:0]  host_address;
		word_t       host_data;
	} request_t;

	typedef struct packed {
		logic [1:0] effect;
		logic [3:0] register_index;
		logic [7:0] memory_address;
		word_t      value;
	} result_t;

	typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic [15:0] instruction = '0;
	logic [7:0]  host_address = '0;
	word_t       host_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  effect;
	logic [3:0]  register_index;
	logic [7:0]  memory_address;
	word_t       value;

	request_t pending_requests[$];
	result_t  expected_results[$];
	word_t    shadow_regs [REG_COUNT];
	word_t    shadow_mem [DATA_WORDS];
	int       failures = 0;
	int       cycle_count = 0;

	toy_cpu_decode_execute DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.instruction    (instruction),
		.host_address   (host_address),
		.host_data      (host_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.effect         (effect),
		.register_index (register_index),
		.memory_address (memory_address),
		.value          (value)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t apply_request(request_t rq);
		result_t    r;
		logic [3:0] op;
		logic [3:0] hi;
		logic [3:0] mid;
		logic [3:0] lo;
		mem_addr_t  addr;
		word_t      v;
		r = '0;
		op = rq.instruction[3:0];
		hi = rq.instruction[15:12];
		mid = rq.instruction[11:8];
		lo = rq.instruction[7:4];
		addr = rq.instruction[11:4];
		case (rq.action)
		ACT_HOST_WR: begin
			shadow_mem[rq.host_address] = rq.host_data;
			r.effect = EFF_MEM_WR;
			r.memory_address = rq.host_address;
			r.value = rq.host_data;
		end
		ACT_HOST_RD: begin
			r.effect = EFF_HOST_RD;
			r.memory_address = rq.host_address;
			r.value = shadow_mem[rq.host_address];
		end
		ACT_EXEC: begin
			case (op)
			OP_ADD, OP_SUB: begin
				if (op == OP_ADD)
					v = shadow_regs[hi] + shadow_regs[mid];
				else
					v = shadow_regs[hi] - shadow_regs[mid];
				shadow_regs[lo] = v;
				r.effect = EFF_REG_WR;
				r.register_index = lo;
				r.value = v;
			end
			OP_LOAD: begin
				v = shadow_mem[addr];
				shadow_regs[hi] = v;
				r.effect = EFF_REG_WR;
				r.register_index = hi;
				r.memory_address = addr;
				r.value = v;
			end
			OP_STORE: begin
				v = shadow_regs[hi];
				shadow_mem[addr] = v;
				r.effect = EFF_MEM_WR;
				r.memory_address = addr;
				r.value = v;
			end
			default: ;
			endcase
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] encode(logic [3:0] op, logic [11:0] operands);
		return {operands, op};
	endfunction

	function automatic word_t random_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 32'h8000_0000;
		default: return $urandom();
		endcase
	endfunction

	// Half the addresses come from a small pool so loads and reads hit earlier writes.
	function automatic logic [7:0] random_address();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		return 8'({$urandom_range(0, 1), 7'd0} | $urandom_range(0, 11));
	endfunction

	task automatic queue_request(logic [1:0] act, logic [15:0] ins, logic [7:0] addr, word_t data);
		pending_requests.push_back({act, ins, addr, data});
	endtask

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			failures++;
		end
	endtask

	initial begin
		logic [3:0] op;
		int         kind;
		for (int i = 0; i < REG_COUNT; i++)
			shadow_regs[i] = '0;
		for (int i = 0; i < DATA_WORDS; i++)
			shadow_mem[i] = '0;

		queue_request(ACT_HOST_WR, 16'hFFFF, 8'd0, 32'hFFFF_FFFF);
		queue_request(ACT_HOST_WR, 16'h0000, 8'd255, 32'h8000_0001);
		queue_request(ACT_HOST_RD, 16'h0000, 8'd0, 32'hFFFF_FFFF);
		queue_request(ACT_HOST_RD, 16'hFFFF, 8'd255, 32'h0000_0000);
		queue_request(ACT_HOST_RD, 16'h0000, 8'd77, 32'h0000_0000);
		queue_request(ACT_EXEC, encode(OP_LOAD, {4'd1, 8'd0}), 8'hFF, 32'hFFFF_FFFF);
		queue_request(ACT_EXEC, encode(OP_LOAD, {4'd15, 8'd255}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_ADD, {4'd1, 4'd15, 4'd2}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_SUB, {4'd0, 4'd1, 4'd3}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_SUB, {4'd0, 4'd15, 4'd4}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_ADD, {4'd1, 4'd1, 4'd1}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_SUB, {4'd15, 4'd15, 4'd15}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_STORE, {4'd2, 8'd128}), 8'h00, 32'h0);
		queue_request(ACT_HOST_RD, 16'h0000, 8'd128, 32'h0);
		queue_request(ACT_EXEC, encode(OP_LOAD, {4'd5, 8'd128}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_ADD, {4'd5, 4'd5, 4'd6}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_STORE, {4'd6, 8'd0}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_LOAD, {4'd0, 8'd0}), 8'h00, 32'h0);
		queue_request(ACT_HOST_WR, 16'h0000, 8'd3, 32'h5A5A_A5A5);
		queue_request(ACT_EXEC, encode(OP_LOAD, {4'd7, 8'd3}), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_STORE, {4'd3, 8'd3}), 8'h00, 32'h0);
		queue_request(ACT_HOST_RD, 16'h0000, 8'd3, 32'h0);
		queue_request(ACT_EXEC, encode(OP_UNUSED_LOW, 12'hFFF), 8'hFF, 32'hFFFF_FFFF);
		queue_request(ACT_EXEC, encode(OP_UNUSED_MID, 12'h123), 8'h00, 32'h0);
		queue_request(ACT_EXEC, encode(OP_UNUSED_HIGH, 12'hFFF), 8'h00, 32'h0);
		queue_request(ACT_RESERVED, encode(OP_ADD, 12'hFFF), 8'hFF, 32'hFFFF_FFFF);

		for (int n = 0; n < RANDOM_ACTIONS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				queue_request(ACT_HOST_WR, 16'($urandom()), random_address(), random_word());
			end else if (kind < 25) begin
				queue_request(ACT_HOST_RD, 16'($urandom()), random_address(), random_word());
			end else if (kind < 90) begin
				case ($urandom_range(0, 3))
				0: op = OP_ADD;
				1: op = OP_SUB;
				2: op = OP_LOAD;
				default: op = OP_STORE;
				endcase
				if (op == OP_LOAD || op == OP_STORE)
					queue_request(ACT_EXEC, encode(op, {4'($urandom()), random_address()}),
						8'($urandom()), random_word());
				else
					queue_request(ACT_EXEC, encode(op, 12'($urandom())), 8'($urandom()),
						random_word());
			end else if (kind < 97) begin
				op = 4'($urandom());
				while (op == OP_ADD || op == OP_SUB || op == OP_LOAD || op == OP_STORE)
					op = 4'($urandom());
				queue_request(ACT_EXEC, encode(op, 12'($urandom())), 8'($urandom()),
					random_word());
			end else begin
				queue_request(ACT_RESERVED, 16'($urandom()), 8'($urandom()), random_word());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("toy_cpu_decode_execute_test OK");
		else
			$display("toy_cpu_decode_execute_test NOT OK");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : sender
		request_t  next_req;
		static int burst_left = 0;
		static int gap_left = 0;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_request({action, instruction, host_address,
					host_data}));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					action <= next_req.action;
					instruction <= next_req.instruction;
					host_address <= next_req.host_address;
					host_data <= next_req.host_data;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver runs one long hold-off so the core fills and drops in_ready.
	always @(posedge clk or negedge arst_n) begin : receiver
		static rx_mode_t mode = RX_STREAM;
		static int mode_left = 0;
		static int phase = 0;
		static int transfers = 0;
		static int hold_left = 0;
		static bit hold_done = 1'b0;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				transfers++;
			if (!hold_done && transfers >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				phase = (phase + 1) % 5;
				case (mode)
				RX_STREAM:   out_ready <= 1'b1;
				RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: out_ready <= (phase < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %0h %0h %0h %0h",
					$time, effect, register_index, memory_address, value);
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("effect", 32'(want.effect), 32'(effect));
				check_field("register_index", 32'(want.register_index), 32'(register_index));
				check_field("memory_address", 32'(want.memory_address), 32'(memory_address));
				check_field("value", want.value, value);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("toy_cpu_decode_execute_test NOT OK");
			$finish;
		end
	end

endmodule

// ===== toy_cpu_decode_execute.f =====
hdl/tcde_pkg.sv
hdl/tcde_ram.sv
hdl/toy_cpu_decode_execute.sv
tb/toy_cpu_decode_execute_test.sv
